// ===== sv/clnsq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnsq_pkg
// Shared types, codes and constant tables for the character LCD nibble
// sequencer.
// ----------------------------------------------------------------------------
package clnsq_pkg;

    localparam int LINE_LENGTH  = 16;
    localparam int COL_W        = (LINE_LENGTH > 2) ? $clog2(LINE_LENGTH) : 1;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int STEP_W       = 5;
    localparam int INIT_EVENTS  = 29;
    localparam int BYTE_EVENTS  = 4;
    localparam int WRAP_EVENTS  = 8;

    localparam logic [7:0] INIT_WAIT_MS   = 8'd20;
    localparam logic [7:0] PULSE_HOLD_RST = 8'd2;
    localparam logic [7:0] SET_ADDR_CMD   = 8'h80;
    localparam logic [7:0] ROW2_ADDR      = 8'h40;
    localparam logic [7:0] ROW1_ADDR      = 8'h00;
    localparam logic [3:0] WAKE_NIBBLE    = 4'h3;
    localparam logic [3:0] MODE4_NIBBLE   = 4'h2;
    localparam logic [2:0] WAKE1_EXTRA_MS = 3'd5;
    localparam logic [2:0] WAKE2_EXTRA_MS = 3'd1;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_INSTR = 2'd1;
    localparam logic [1:0] OP_DATA  = 2'd2;
    localparam logic [1:0] OP_CHAR  = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] byte_value;
        logic [8:0] post_wait_ms;
        logic       first_of_string;
    } in_item_t;

    typedef struct packed {
        logic [3:0] data_nibble;
        logic       reg_select;
        logic       enable;
        logic [9:0] hold_ms;
        logic       last;
    } out_item_t;

    typedef enum logic {
        JOB_INIT = 1'b0,
        JOB_BYTE = 1'b1
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] byte_value;
        logic       reg_select;
        logic       wrap;
        logic       second_row;
        logic [8:0] post_wait_ms;
    } job_t;

    typedef struct packed {
        logic [3:0] nibble;
        logic       enable;
        logic       fixed_wait;
        logic [2:0] extra_ms;
    } init_event_t;

    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        begin
            b = 8'h0F;
            case (idx)
                3'd0:    b = 8'h28;
                3'd1:    b = 8'h80;
                3'd2:    b = 8'h01;
                3'd3:    b = 8'h06;
                default: b = 8'h0F;
            endcase
            return b;
        end
    endfunction

    function automatic init_event_t init_event(input logic [STEP_W-1:0] step);
        init_event_t ev;
        logic [2:0]  p;
        logic [4:0]  k;
        logic [7:0]  b;
        begin
            ev = '0;
            p  = 3'(step - STEP_W'(1));
            k  = 5'(step - STEP_W'(9));
            b  = init_byte(k[4:2]);
            if (step == '0)
            begin
                ev.fixed_wait = 1'b1;
            end
            else if (step <= STEP_W'(8))
            begin
                ev.enable = ~p[0];
                ev.nibble = (p[2:1] == 2'd3) ? MODE4_NIBBLE : WAKE_NIBBLE;
                if (!p[0])
                    ev.extra_ms = '0;
                else if (p[2:1] == 2'd0)
                    ev.extra_ms = WAKE1_EXTRA_MS;
                else if (p[2:1] == 2'd3)
                    ev.extra_ms = '0;
                else
                    ev.extra_ms = WAKE2_EXTRA_MS;
            end
            else
            begin
                ev.enable = ~k[0];
                ev.nibble = k[1] ? b[3:0] : b[7:4];
            end
            return ev;
        end
    endfunction

endpackage

// ===== sv/clnsq_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnsq_queue
// Short job queue between the classifier front and the pin-event back.
// ----------------------------------------------------------------------------
module clnsq_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  clnsq_pkg::job_t wr_job,
    output logic          full,
    input  logic          rd_en,
    output clnsq_pkg::job_t rd_job,
    output logic          not_empty
);
    import clnsq_pkg::*;

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_wr;
    logic              do_rd;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_job    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + (QPTR_W+1)'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - (QPTR_W+1)'(1);
        end
    end

endmodule

// ===== sv/clnsq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnsq_front
// Accepts commands, tracks string column and row, and turns each command
// into a job for the back end.
// ----------------------------------------------------------------------------
module clnsq_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  clnsq_pkg::in_item_t in_item,
    input  logic               q_full,
    output logic               job_wr,
    output clnsq_pkg::job_t     job
);
    import clnsq_pkg::*;

    logic [COL_W-1:0] column_reg;
    logic [COL_W-1:0] column_next;
    logic             row_reg;
    logic             row_next;
    logic [COL_W-1:0] col_cur;
    logic             row_cur;
    logic             at_end;

    assign job_wr  = push && !q_full;
    assign col_cur = in_item.first_of_string ? '0 : column_reg;
    assign row_cur = in_item.first_of_string ? 1'b0 : row_reg;
    assign at_end  = (col_cur >= COL_W'(LINE_LENGTH - 1));

    always_comb
    begin
        job              = '0;
        job.byte_value   = in_item.byte_value;
        job.post_wait_ms = in_item.post_wait_ms;
        column_next      = column_reg;
        row_next         = row_reg;
        unique case (in_item.op)
            OP_INIT:
            begin
                job.kind = JOB_INIT;
            end
            OP_INSTR:
            begin
                job.kind = JOB_BYTE;
            end
            OP_DATA:
            begin
                job.kind       = JOB_BYTE;
                job.reg_select = 1'b1;
            end
            default:
            begin
                job.kind       = JOB_BYTE;
                job.reg_select = 1'b1;
                job.wrap       = at_end;
                job.second_row = ~row_cur;
                column_next    = at_end ? '0 : col_cur + COL_W'(1);
                row_next       = at_end ? ~row_cur : row_cur;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= 1'b0;
        end
        else if (job_wr)
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

endmodule

// ===== sv/clnsq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnsq_back
// Steps through the pin events of the job at the queue head, one event per
// cycle while the output is empty or being popped, into an output register.
// ----------------------------------------------------------------------------
module clnsq_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_data,
    input  logic                job_valid,
    input  clnsq_pkg::job_t      job,
    output logic                job_rd,
    output logic                empty,
    input  logic                pop,
    output clnsq_pkg::out_item_t out_item
);
    import clnsq_pkg::*;

    logic [7:0]        pulse_hold_reg;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_reg;
    out_item_t         out_next;
    out_item_t         ev;
    init_event_t       iev;
    logic              advance;
    logic              is_last;
    logic              en;
    logic              fixed_wait;
    logic [2:0]        extra_ms;
    logic [7:0]        cur_byte;
    logic [7:0]        base_ms;

    assign advance = job_valid && (!out_valid_reg || pop);
    assign iev     = init_event(step_reg);

    always_comb
    begin
        cur_byte   = job.byte_value;
        ev         = '0;
        en         = ~step_reg[0];
        fixed_wait = 1'b0;
        extra_ms   = '0;
        is_last    = 1'b0;
        if (job.kind == JOB_INIT)
        begin
            en         = iev.enable;
            fixed_wait = iev.fixed_wait;
            extra_ms   = iev.extra_ms;
            ev.data_nibble = iev.nibble;
            is_last    = (step_reg == STEP_W'(INIT_EVENTS - 1));
        end
        else
        begin
            if (step_reg[2])
                cur_byte = SET_ADDR_CMD | (job.second_row ? ROW2_ADDR : ROW1_ADDR);
            ev.data_nibble = step_reg[1] ? cur_byte[3:0] : cur_byte[7:4];
            ev.reg_select  = job.reg_select && !step_reg[2];
            is_last = job.wrap ? (step_reg == STEP_W'(WRAP_EVENTS - 1))
                               : (step_reg == STEP_W'(BYTE_EVENTS - 1));
        end
        base_ms    = fixed_wait ? INIT_WAIT_MS : pulse_hold_reg;
        ev.enable  = en;
        ev.last    = is_last;
        ev.hold_ms = {2'b00, base_ms}
                   + (en ? 10'd0 : {7'b0, extra_ms})
                   + (is_last ? {1'b0, job.post_wait_ms} : 10'd0);
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        step_next      = step_reg;
        job_rd         = 1'b0;
        if (advance)
        begin
            out_next       = ev;
            out_valid_next = 1'b1;
            if (is_last)
            begin
                step_next = '0;
                job_rd    = 1'b1;
            end
            else
            begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_hold_reg <= PULSE_HOLD_RST;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                pulse_hold_reg <= cfg_data;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

endmodule

// ===== sv/char_lcd_nibble_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core
// Character LCD controller for a 4-bit bus: expands commands into pin events
// with hold times in milliseconds.
// ----------------------------------------------------------------------------
// first event of a command goes through the job queue, then the output register
// throughput: one pin event per cycle from the back-end step counter while the
//   output is empty or popped; 4 events per byte, 8 on a line wrap, 29 for init
// a 4-entry job queue lets up to 4 commands be taken ahead of the events
// reset: queue and output empty, column 0, first row, pulse hold 2 ms
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  clnsq_pkg::in_item_t   in_item,
    output logic                 empty,
    input  logic                 pop,
    output clnsq_pkg::out_item_t  out_item,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_data
);
    import clnsq_pkg::*;

    logic job_wr;
    job_t job_in;
    job_t job_head;
    logic job_valid;
    logic job_rd;

    clnsq_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .in_item (in_item),
        .q_full  (full),
        .job_wr  (job_wr),
        .job     (job_in)
    );

    clnsq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (job_wr),
        .wr_job    (job_in),
        .full      (full),
        .rd_en     (job_rd),
        .rd_job    (job_head),
        .not_empty (job_valid)
    );

    clnsq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .job_valid (job_valid),
        .job       (job_head),
        .job_rd    (job_rd),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item)
    );

    // last event of every command drops enable
    a_last_low: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.last) |-> !out_item.enable)
        else $error("last event with enable high");

    // a job is only read out when the queue holds one
    a_rd_valid: assert property (@(posedge clk) disable iff (!rst_n)
        job_rd |-> job_valid)
        else $error("job read from empty queue");

    // an event appears only when a job was waiting
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(empty) |-> $past(job_valid))
        else $error("event without a job");

endmodule
